>>> src/hqs_pkg.sv
// Package for the hybrid quicksort engine: sizes, the stored element type and
// the range stack entry type. No dependencies.
`default_nettype none
package hqs_pkg;
    localparam int DEPTH       = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int CUTOFF_SIZE = 3;
    localparam int STACK_DEPTH = 20;
    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SLW = $clog2(STACK_DEPTH + 1);
    localparam int EW  = KEY_WIDTH + AW;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [AW-1:0]        idx;
    } t_elem;

    typedef struct packed {
        logic [AW:0] lo;
        logic [AW:0] hi;
    } t_range;
endpackage
`default_nettype wire

>>> src/hqs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module hqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/hybrid_quicksort_engine_core.sv
// Top level of the hybrid quicksort engine: load, sort sequencer and output.
// Depends on hqs_pkg and hqs_ram.
//
// Usage. Keys arrive on the input channel (i_valid/o_ready, payload i_key,
// i_last_in), one transaction per key and one cycle per key while loading.
// Each key is written into the element memory with its arrival index; keys
// beyond DEPTH are dropped and flag overflow on every result of the set. The
// transaction that carries i_last_in starts the sort. o_ready then stays low
// until the final result of the set has moved into the output register.
// The sort works on one element memory (one write and one registered read per
// cycle) and a range stack memory. Reads are pipelined. Input already in order
// is the worst case for sort time.
// After the sort and a read set-up state, the results leave in ascending
// order on the output channel (o_valid/i_ready), one transaction per cycle
// while the receiver is ready, with o_last_out on the final one. When the
// receiver stalls, the result waits in the one-entry output register and the
// read-out pauses.
// Reset (i_rst_n low, synchronous) returns the block to loading an empty set;
// the memories are not cleared, since only written entries are ever read.
`default_nettype none
module hybrid_quicksort_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_key,
    input  wire logic        i_last_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [31:0] o_sorted_key,
    output logic      [5:0]  o_source_index,
    output logic             o_last_out,
    output logic             o_overflow
);
    import hqs_pkg::*;

    // Sequencer states. Each memory read is issued in one state and its data
    // used in the next.
    typedef enum logic [15:0] {
        S_LOAD  = 16'h0001,
        S_TOP   = 16'h0002, // decide on current range lo..hi
        S_PIV   = 16'h0004, // pivot read data arrives
        S_BRD   = 16'h0008, // key[b] data arrives (scan from the right)
        S_ARD   = 16'h0010, // key[a] data arrives (scan from the left)
        S_PLACE = 16'h0020, // write pivot into its hole, push range
        S_INS   = 16'h0040, // insertion: start element b
        S_IKD   = 16'h0080, // insertion: key[b] data arrives
        S_IAD   = 16'h0100, // insertion: key[a] data arrives
        S_POP   = 16'h0200, // stack read issued
        S_POPD  = 16'h0400, // stack data arrives
        S_OUTR  = 16'h0800, // read for output issued
        S_OUTD  = 16'h1000, // output data arrives
        S_OUTW  = 16'h2000, // waiting for the output register to drain
        S_IFIN  = 16'h4000  // insertion: held key written at the range bottom
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]    r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [SLW-1:0]   r_sp, n_sp;
    logic [AW:0]      r_lo, n_lo, r_hi, n_hi, r_a, n_a, r_b, n_b;
    t_elem            r_piv, n_piv;     // pivot, or key being inserted
    logic [CW-1:0]    r_oc, n_oc;       // read-out position

    // Element memory port signals.
    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    t_elem         m_wdata, m_rdata;
    // Range stack port signals.
    logic          s_we;
    logic [SW-1:0] s_waddr, s_raddr;
    t_range        s_wdata, s_rdata;

    // Output register.
    logic          r_ov;
    t_elem         r_oe;
    logic          r_olast, r_oovf;
    logic          load_out;
    logic          out_free;

    hqs_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_elem (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    hqs_ram #(.WIDTH(2 * (AW + 1)), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_sp    = r_sp;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_a     = r_a;
        n_b     = r_b;
        n_piv   = r_piv;
        n_oc    = r_oc;
        m_we    = 1'b0;
        m_waddr = r_a[AW-1:0];
        m_wdata = r_piv;
        m_raddr = r_a[AW-1:0];
        s_we    = 1'b0;
        s_waddr = r_sp[SW-1:0];
        s_wdata = '{lo: r_lo, hi: r_hi};
        s_raddr = r_sp[SW-1:0];
        load_out = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_count < CW'(DEPTH)) begin
                        m_we    = 1'b1;
                        m_waddr = r_count[AW-1:0];
                        m_wdata = '{key: i_key[KEY_WIDTH-1:0],
                                    idx: r_count[AW-1:0]};
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_in) begin
                        n_lo    = '0;
                        n_hi    = (r_count < CW'(DEPTH))
                                ? (AW+1)'(r_count) : (AW+1)'(DEPTH - 1);
                        n_sp    = '0;
                        n_state = S_TOP;
                    end
                end
            end
            S_TOP: begin
                // A range left empty by a partition has hi one below lo; when
                // lo is zero that wraps to all ones, so the top bit marks it.
                if (r_hi[AW] || (r_hi < r_lo)) begin
                    n_state = S_POP;
                end else if (((AW+2)'(r_hi) - (AW+2)'(r_lo) <= (AW+2)'(CUTOFF_SIZE)) ||
                             (r_sp >= SLW'(STACK_DEPTH))) begin
                    n_b     = r_lo + 1'b1;
                    n_state = S_INS;
                end else begin
                    m_raddr = r_lo[AW-1:0];
                    n_a     = r_lo;
                    n_b     = r_hi;
                    n_state = S_PIV;
                end
            end
            S_PIV: begin
                n_piv   = m_rdata;
                m_raddr = r_b[AW-1:0];
                n_state = S_BRD;
            end
            S_BRD: begin
                // while a<b && key[b] >= pk: b--
                if (m_rdata.key >= r_piv.key) begin
                    n_b = r_b - 1'b1;
                    if (r_a < n_b) begin
                        m_raddr = n_b[AW-1:0];
                        n_state = S_BRD;
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    m_we    = 1'b1;
                    m_waddr = r_a[AW-1:0];
                    m_wdata = m_rdata;
                    n_a     = r_a + 1'b1;
                    if (n_a < r_b) begin
                        m_raddr = n_a[AW-1:0];
                        n_state = S_ARD;
                    end else begin
                        n_state = S_PLACE;
                    end
                end
            end
            S_ARD: begin
                if (m_rdata.key <= r_piv.key) begin
                    n_a = r_a + 1'b1;
                    if (n_a < r_b) begin
                        m_raddr = n_a[AW-1:0];
                        n_state = S_ARD;
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    m_we    = 1'b1;
                    m_waddr = r_b[AW-1:0];
                    m_wdata = m_rdata;
                    n_b     = r_b - 1'b1;
                    if (r_a < n_b) begin
                        m_raddr = n_b[AW-1:0];
                        n_state = S_BRD;
                    end else begin
                        n_state = S_PLACE;
                    end
                end
            end
            S_PLACE: begin
                m_we    = 1'b1;
                m_waddr = r_a[AW-1:0];
                m_wdata = r_piv;
                s_we    = 1'b1;
                if ((r_hi - r_a) >= (r_a - r_lo)) begin
                    s_wdata = '{lo: r_a + 1'b1, hi: r_hi};
                    n_hi    = r_a - 1'b1;
                end else begin
                    s_wdata = '{lo: r_lo, hi: r_a - 1'b1};
                    n_lo    = r_a + 1'b1;
                end
                n_sp    = r_sp + 1'b1;
                n_state = S_TOP;
            end
            S_INS: begin
                if (r_b > r_hi) begin
                    n_state = S_POP;
                end else begin
                    m_raddr = r_b[AW-1:0];
                    n_state = S_IKD;
                end
            end
            S_IKD: begin
                n_piv   = m_rdata;
                n_a     = r_b - 1'b1;
                m_raddr = n_a[AW-1:0];
                n_state = S_IAD;
            end
            S_IAD: begin
                // a >= lo holds on entry; a larger key[a] moves up one place
                m_we    = 1'b1;
                m_waddr = AW'(r_a + 1'b1);
                if (r_piv.key < m_rdata.key) begin
                    m_wdata = m_rdata;
                    n_a     = r_a - 1'b1;
                    if (r_a > r_lo) begin
                        m_raddr = n_a[AW-1:0];
                        n_state = S_IAD;
                    end else begin
                        n_state = S_IFIN;
                    end
                end else begin
                    m_wdata = r_piv;
                    n_b     = r_b + 1'b1;
                    n_state = S_INS;
                end
            end
            S_IFIN: begin
                // The write port was busy with the last shift, so the held
                // key goes into the freed bottom slot in the next cycle.
                m_we    = 1'b1;
                m_waddr = AW'(r_a + 1'b1);
                m_wdata = r_piv;
                n_b     = r_b + 1'b1;
                n_state = S_INS;
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_oc    = '0;
                    n_state = S_OUTR;
                end else begin
                    n_sp    = r_sp - 1'b1;
                    s_raddr = SW'(r_sp - 1'b1);
                    n_state = S_POPD;
                end
            end
            S_POPD: begin
                n_lo    = s_rdata.lo;
                n_hi    = s_rdata.hi;
                n_state = S_TOP;
            end
            S_OUTR: begin
                m_raddr = r_oc[AW-1:0];
                n_state = S_OUTD;
            end
            S_OUTD, S_OUTW: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_oc     = r_oc + 1'b1;
                    if (n_oc == r_count) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_sp    = '0;
                        n_state = S_LOAD;
                    end else begin
                        m_raddr = n_oc[AW-1:0];
                        n_state = S_OUTD;
                    end
                end else begin
                    m_raddr = r_oc[AW-1:0];
                    n_state = S_OUTW;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_sp    <= n_sp;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_a   <= n_a;
        r_b   <= n_b;
        r_piv <= n_piv;
        r_oc  <= n_oc;
        if (load_out) begin
            r_oe    <= m_rdata;
            r_olast <= ((r_oc + 1'b1) == r_count);
            r_oovf  <= r_ovf;
        end
    end

    assign o_valid        = r_ov;
    assign o_sorted_key   = 32'(r_oe.key);
    assign o_source_index = 6'(r_oe.idx);
    assign o_last_out     = r_olast;
    assign o_overflow     = r_oovf;
endmodule
`default_nettype wire

>>> src/hqs_checker.sv
// Port-level checker for the hybrid quicksort engine, bound to the top level.
// Depends on hybrid_quicksort_engine_core.
`default_nettype none
module hqs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_sorted_key,
    input wire logic        o_last_out
);
    // While loading, only the final result of the previous set may still wait.
    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ready) |-> o_last_out)
        else $error("input ready during read-out");

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sorted_key)))
        else $error("stalled result changed");

    // Results accepted in consecutive cycles within a set are in ascending order.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_out) ##1 (o_valid && i_ready)
        |-> (o_sorted_key >= $past(o_sorted_key)))
        else $error("results out of order");
endmodule

bind hybrid_quicksort_engine_core hqs_checker u_hqs_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_sorted_key(o_sorted_key),
    .o_last_out(o_last_out)
);
`default_nettype wire
